// ===== src/bsr_pkg.sv =====
package bsr_pkg;

   // command codes; code 7 is treated as print
   localparam logic [2:0] KIND_PUSH     = 3'd0;
   localparam logic [2:0] KIND_POP      = 3'd1;
   localparam logic [2:0] KIND_PEEK     = 3'd2;
   localparam logic [2:0] KIND_DUP      = 3'd3;
   localparam logic [2:0] KIND_ROT_UP   = 3'd4;
   localparam logic [2:0] KIND_ROT_DOWN = 3'd5;
   localparam logic [2:0] KIND_PRINT    = 3'd6;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam int         MAX_RESULTS       = 64;
   localparam int         LIMIT_WIDTH       = 7;
   localparam logic [6:0] STACK_LIMIT_RESET = 7'd64;

endpackage

// ===== src/bsr_mem.sv =====
module bsr_mem #(
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [7:0]                 rd_data,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [7:0]                 wr_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bsr_ctrl.sv =====
module bsr_ctrl
   import bsr_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [LIMIT_WIDTH-1:0]     limit,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [2:0]                 req_kind,
   input  logic [7:0]                 req_push_byte,
   input  logic [3:0]                 req_rotate_count,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic [7:0]                 rsp_data,
   output logic                       rsp_data_valid,
   output logic                       rsp_last,
   output logic                       mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]   mem_rd_addr,
   input  logic [7:0]                 mem_rd_data,
   output logic                       mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]   mem_wr_addr,
   output logic [7:0]                 mem_wr_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int RW = $clog2(MAX_RESULTS + 1);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_EXEC    = 7'b0000010,
      ST_RESP    = 7'b0000100,
      ST_ROT_RD  = 7'b0001000,
      ST_ROT_WR  = 7'b0010000,
      ST_ROT_FIN = 7'b0100000,
      ST_PR_OUT  = 7'b1000000
   } state_type;

   state_type     state_ff, state_in;
   logic [2:0]    kind_ff, kind_in;
   logic [7:0]    byte_ff, byte_in;
   logic [3:0]    n_ff, n_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [RW-1:0] remain_ff, remain_in;
   logic [7:0]    tmp_ff, tmp_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [7:0]    res_data_ff, res_data_in;
   logic          res_dv_ff, res_dv_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic          rsp_dv_ff, rsp_dv_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [CW-1:0] count_m1;
   logic [CW-1:0] lo_req;
   logic [CW-1:0] lo_cur;
   logic          full;
   logic          empty;
   logic          rot_ok;
   logic          rot_up;
   logic          out_free;
   logic          load;
   logic [1:0]    load_status;
   logic [7:0]    load_data;
   logic          load_dv;
   logic          load_last;

   assign count_m1 = count_ff - CW'(1);
   assign lo_req   = count_ff - CW'(req_rotate_count);
   assign lo_cur   = count_ff - CW'(n_ff);
   // effective limit is min(limit, DEPTH)
   assign full     = (int'(count_ff) >= int'(limit)) || (int'(count_ff) >= DEPTH);
   assign empty    = (count_ff == '0);
   assign rot_ok   = (n_ff > 4'd1) && (int'(n_ff) <= int'(count_ff));
   assign rot_up   = (kind_ff == KIND_ROT_UP);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      byte_in       = byte_ff;
      n_in          = n_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      remain_in     = remain_ff;
      tmp_in        = tmp_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      res_dv_in     = res_dv_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = count_m1[AW-1:0];
      mem_wr_en     = 1'b0;
      mem_wr_addr   = ptr_ff;
      mem_wr_data   = mem_rd_data;
      load          = 1'b0;
      load_status   = STATUS_OK;
      load_data     = 8'd0;
      load_dv       = 1'b0;
      load_last     = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               byte_in   = req_push_byte;
               n_in      = req_rotate_count;
               mem_rd_en = 1'b1;
               // rotate down needs the deepest entry of the group, all else the top
               if (req_kind == KIND_ROT_DOWN) begin
                  mem_rd_addr = lo_req[AW-1:0];
               end
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_status_in = STATUS_OK;
            res_data_in   = 8'd0;
            res_dv_in     = 1'b0;
            state_in      = ST_RESP;
            case (kind_ff)
               KIND_PUSH: begin
                  if (full) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = count_ff[AW-1:0];
                     mem_wr_data = byte_ff;
                     count_in    = count_ff + CW'(1);
                  end
               end
               KIND_POP, KIND_PEEK: begin
                  if (empty) begin
                     res_status_in = STATUS_EMPTY;
                  end else begin
                     res_data_in = mem_rd_data;
                     res_dv_in   = 1'b1;
                     if (kind_ff == KIND_POP) begin
                        count_in = count_m1;
                     end
                  end
               end
               KIND_DUP: begin
                  if (full) begin
                     res_status_in = STATUS_FULL;
                  end else if (empty) begin
                     res_status_in = STATUS_EMPTY;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = count_ff[AW-1:0];
                     mem_wr_data = mem_rd_data;
                     count_in    = count_ff + CW'(1);
                  end
               end
               KIND_ROT_UP, KIND_ROT_DOWN: begin
                  if (rot_ok) begin
                     tmp_in    = mem_rd_data;
                     remain_in = RW'(n_ff - 4'd1);
                     ptr_in    = rot_up ? count_m1[AW-1:0] : lo_cur[AW-1:0];
                     state_in  = ST_ROT_RD;
                  end
               end
               default: begin
                  if (empty) begin
                     state_in = ST_IDLE;
                  end else begin
                     ptr_in    = count_m1[AW-1:0];
                     remain_in = (int'(count_ff) < MAX_RESULTS) ? RW'(count_ff)
                                                                : RW'(MAX_RESULTS);
                     state_in  = ST_PR_OUT;
                  end
               end
            endcase
         end
         ST_RESP: begin
            if (out_free) begin
               load        = 1'b1;
               load_status = res_status_ff;
               load_data   = res_data_ff;
               load_dv     = res_dv_ff;
               state_in    = ST_IDLE;
            end
         end
         ST_ROT_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = rot_up ? (ptr_ff - AW'(1)) : (ptr_ff + AW'(1));
            state_in    = ST_ROT_WR;
         end
         ST_ROT_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ptr_ff;
            mem_wr_data = mem_rd_data;
            ptr_in      = rot_up ? (ptr_ff - AW'(1)) : (ptr_ff + AW'(1));
            remain_in   = remain_ff - RW'(1);
            state_in    = (remain_ff == RW'(1)) ? ST_ROT_FIN : ST_ROT_RD;
         end
         ST_ROT_FIN: begin
            // pointer has landed on the slot the saved byte goes to
            mem_wr_en   = 1'b1;
            mem_wr_addr = ptr_ff;
            mem_wr_data = tmp_ff;
            state_in    = ST_RESP;
         end
         ST_PR_OUT: begin
            if (out_free) begin
               load      = 1'b1;
               load_data = mem_rd_data;
               load_dv   = 1'b1;
               load_last = (remain_ff == RW'(1));
               if (remain_ff == RW'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = ptr_ff - AW'(1);
                  ptr_in      = ptr_ff - AW'(1);
                  remain_in   = remain_ff - RW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_dv_in     = rsp_dv_ff;
      rsp_last_in   = rsp_last_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = load_status;
         rsp_data_in   = load_data;
         rsp_dv_in     = load_dv;
         rsp_last_in   = load_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      byte_ff       <= byte_in;
      n_ff          <= n_in;
      ptr_ff        <= ptr_in;
      remain_ff     <= remain_in;
      tmp_ff        <= tmp_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      res_dv_ff     <= res_dv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_dv_ff     <= rsp_dv_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data       = rsp_data_ff;
   assign rsp_data_valid = rsp_dv_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== src/byte_stack_with_rotate_top.sv =====
// Byte-wide LIFO stack of DEPTH entries held in one synchronous RAM, with push,
// pop, peek, dup, rotate up/down of the top n entries and print (top to bottom,
// last result flagged, nothing for an empty stack). The capacity is
// min(csr limit, DEPTH); the limit resets to 64 and should be written only while
// the block is idle. One command is handled at a time. Push, pop, peek, dup and
// a rotate that does nothing pass through EXEC and RESP; an active rotate goes
// through ROT_RD and ROT_WR for each shifted entry, as each costs a RAM read and a
// RAM write through the single read and write port, then ROT_FIN and RESP; print
// emits the entries one after another, with at most 64 entries emitted. A result
// waits in an output register and the next command is accepted once the last
// result of the previous one has been loaded there. Back-pressure on the result
// side stalls print and the single-result commands alike.
module byte_stack_with_rotate_top
   import bsr_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [LIMIT_WIDTH-1:0] csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_kind,
   input  logic [7:0]             req_push_byte,
   input  logic [3:0]             req_rotate_count,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [7:0]             rsp_data,
   output logic                   rsp_data_valid,
   output logic                   rsp_last
);

   localparam int AW = $clog2(DEPTH);

   logic [LIMIT_WIDTH-1:0] limit_ff, limit_in;
   logic                   mem_rd_en;
   logic [AW-1:0]          mem_rd_addr;
   logic [7:0]             mem_rd_data;
   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [7:0]             mem_wr_data;

   assign limit_in = csr_we ? csr_wdata : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= STACK_LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   bsr_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .limit            (limit_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_push_byte    (req_push_byte),
      .req_rotate_count (req_rotate_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_data         (rsp_data),
      .rsp_data_valid   (rsp_data_valid),
      .rsp_last         (rsp_last),
      .mem_rd_en        (mem_rd_en),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data)
   );

   bsr_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

endmodule

// ===== verif/byte_stack_with_rotate_top_test.sv =====
`timescale 1ns / 100ps

module byte_stack_with_rotate_top_test;
   import bsr_pkg::*;

   localparam int         STACK_DEPTH   = 64;
   localparam logic [2:0] KIND_SPARE    = 3'd7;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         CYCLE_LIMIT   = 1000000;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] data;
      logic       data_valid;
      logic       last;
   } stack_result_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [LIMIT_WIDTH-1:0] csr_wdata;
   logic                   req_valid;
   logic                   req_ready;
   logic [2:0]             req_kind;
   logic [7:0]             req_push_byte;
   logic [3:0]             req_rotate_count;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [1:0]             rsp_status;
   logic [7:0]             rsp_data;
   logic                   rsp_data_valid;
   logic                   rsp_last;

   // shadow of the stack, updated as each item is accepted
   logic [7:0]             shadow_stack [STACK_DEPTH];
   int                     shadow_depth;
   logic [LIMIT_WIDTH-1:0] shadow_limit;
   stack_result_type       pending_results [$];
   stack_result_type       oldest;

   int err_count;
   int cycle_count;
   int rx_hold_left;
   bit tx_gaps_on;
   bit rx_stalls_on;

   byte_stack_with_rotate_top #(
      .DEPTH(STACK_DEPTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_push_byte   (req_push_byte),
      .req_rotate_count(req_rotate_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_data        (rsp_data),
      .rsp_data_valid  (rsp_data_valid),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("byte_stack_with_rotate_top_test NOT OK");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      err_count++;
   endtask

   function automatic void queue_result(input logic [1:0] status, input logic [7:0] data,
                                        input logic data_valid, input logic last);
      stack_result_type r;
      r.status     = status;
      r.data       = data;
      r.data_valid = data_valid;
      r.last       = last;
      pending_results.push_back(r);
   endfunction

   function automatic int stack_capacity();
      return (shadow_limit < STACK_DEPTH) ? int'(shadow_limit) : STACK_DEPTH;
   endfunction

   task automatic apply_command(input logic [2:0] kind, input logic [7:0] push_byte,
                                input logic [3:0] n);
      int         lo;
      int         count;
      logic [7:0] moved;
      bit         full;
      bit         empty;
      full  = shadow_depth >= stack_capacity();
      empty = shadow_depth == 0;
      case (kind)
         KIND_PUSH: begin
            if (full) begin
               queue_result(STATUS_FULL, 8'h00, 1'b0, 1'b1);
            end else begin
               shadow_stack[shadow_depth] = push_byte;
               shadow_depth++;
               queue_result(STATUS_OK, 8'h00, 1'b0, 1'b1);
            end
         end
         KIND_POP, KIND_PEEK: begin
            if (empty) begin
               queue_result(STATUS_EMPTY, 8'h00, 1'b0, 1'b1);
            end else begin
               moved = shadow_stack[shadow_depth-1];
               if (kind == KIND_POP) shadow_depth--;
               queue_result(STATUS_OK, moved, 1'b1, 1'b1);
            end
         end
         KIND_DUP: begin
            if (full) begin
               queue_result(STATUS_FULL, 8'h00, 1'b0, 1'b1);
            end else if (empty) begin
               queue_result(STATUS_EMPTY, 8'h00, 1'b0, 1'b1);
            end else begin
               shadow_stack[shadow_depth] = shadow_stack[shadow_depth-1];
               shadow_depth++;
               queue_result(STATUS_OK, 8'h00, 1'b0, 1'b1);
            end
         end
         KIND_ROT_UP: begin
            if (n > 1 && n <= shadow_depth) begin
               lo    = shadow_depth - n;
               moved = shadow_stack[shadow_depth-1];
               for (int i = shadow_depth - 1; i > lo; i--) shadow_stack[i] = shadow_stack[i-1];
               shadow_stack[lo] = moved;
            end
            queue_result(STATUS_OK, 8'h00, 1'b0, 1'b1);
         end
         KIND_ROT_DOWN: begin
            if (n > 1 && n <= shadow_depth) begin
               lo    = shadow_depth - n;
               moved = shadow_stack[lo];
               for (int i = lo; i < shadow_depth - 1; i++) shadow_stack[i] = shadow_stack[i+1];
               shadow_stack[shadow_depth-1] = moved;
            end
            queue_result(STATUS_OK, 8'h00, 1'b0, 1'b1);
         end
         default: begin
            // print, and the spare code that behaves as print
            count = (shadow_depth < MAX_RESULTS) ? shadow_depth : MAX_RESULTS;
            for (int i = 0; i < count; i++)
               queue_result(STATUS_OK, shadow_stack[shadow_depth-1-i], 1'b1, i + 1 == count);
         end
      endcase
   endtask

   task automatic send_command(input logic [2:0] kind, input logic [7:0] push_byte,
                               input logic [3:0] rotate_count);
      int gap;
      gap = 0;
      if (tx_gaps_on && $urandom_range(0, 2) == 0) gap = idle_length();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_kind         = kind;
      req_push_byte    = push_byte;
      req_rotate_count = rotate_count;
      do @(posedge clock); while (!req_ready);
      apply_command(kind, push_byte, rotate_count);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // a print of an empty stack leaves no result to wait for
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_WIDTH-1:0] value);
      drain_results();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = value;
      @(posedge clock);
      shadow_limit = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // result side: long hold-off when asked, otherwise random stalls
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_left > 0) begin
            rsp_ready = 1'b0;
            rx_hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if (rx_stalls_on && $urandom_range(0, 3) == 0) stall_left = idle_length();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing outstanding: status %0d data %02h",
                                      rsp_status, rsp_data));
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_status !== oldest.status)
               report_mismatch($sformatf("status %0d, wanted %0d", rsp_status, oldest.status));
            if (rsp_data !== oldest.data)
               report_mismatch($sformatf("data %02h, wanted %02h", rsp_data, oldest.data));
            if (rsp_data_valid !== oldest.data_valid)
               report_mismatch($sformatf("data_valid %0b, wanted %0b", rsp_data_valid,
                                         oldest.data_valid));
            if (rsp_last !== oldest.last)
               report_mismatch($sformatf("last %0b, wanted %0b", rsp_last, oldest.last));
         end
      end
   end

   task automatic test_push_pop_peek();
      send_command(KIND_POP, 8'h00, 4'd0);
      send_command(KIND_PEEK, 8'h00, 4'd0);
      send_command(KIND_PUSH, 8'h00, 4'd0);
      send_command(KIND_PUSH, 8'hFF, 4'd0);
      send_command(KIND_PEEK, 8'h00, 4'd0);
      send_command(KIND_POP, 8'h00, 4'd0);
      send_command(KIND_POP, 8'h00, 4'd0);
      send_command(KIND_POP, 8'h00, 4'd0);
   endtask

   task automatic test_dup_print();
      send_command(KIND_PRINT, 8'h00, 4'd0);
      send_command(KIND_DUP, 8'h00, 4'd0);
      send_command(KIND_PUSH, 8'h5A, 4'd0);
      send_command(KIND_DUP, 8'h00, 4'd0);
      send_command(KIND_PRINT, 8'h00, 4'd0);
      send_command(KIND_SPARE, 8'h00, 4'd0);
   endtask

   task automatic test_rotate();
      rx_stalls_on = 1'b1;
      send_command(KIND_PUSH, 8'h01, 4'd0);
      send_command(KIND_PUSH, 8'h80, 4'd0);
      send_command(KIND_PUSH, 8'h3C, 4'd0);
      send_command(KIND_ROT_UP, 8'h00, 4'd0);
      send_command(KIND_ROT_DOWN, 8'h00, 4'd1);
      send_command(KIND_ROT_UP, 8'h00, 4'd3);
      send_command(KIND_ROT_DOWN, 8'h00, 4'd5);
      send_command(KIND_ROT_UP, 8'h00, 4'd9);
      send_command(KIND_PRINT, 8'h00, 4'd0);
   endtask

   task automatic test_limits();
      write_limit(7'd0);
      send_command(KIND_PUSH, 8'h11, 4'd0);
      send_command(KIND_DUP, 8'h00, 4'd0);
      // limit raised from zero on an empty stack: growth allowed again, pops run it dry
      write_limit(7'd3);
      send_command(KIND_PUSH, 8'h22, 4'd0);
      send_command(KIND_POP, 8'h00, 4'd0);
      send_command(KIND_POP, 8'h00, 4'd0);
      send_command(KIND_POP, 8'h00, 4'd0);
      send_command(KIND_PUSH, 8'h33, 4'd0);
      send_command(KIND_DUP, 8'h00, 4'd0);
   endtask

   function automatic logic [2:0] pick_kind();
      int r;
      if (shadow_depth >= stack_capacity() && $urandom_range(0, 99) < 40) return KIND_POP;
      r = $urandom_range(0, 99);
      if (r < 35) return KIND_PUSH;
      if (r < 50) return KIND_POP;
      if (r < 58) return KIND_PEEK;
      if (r < 66) return KIND_DUP;
      if (r < 78) return KIND_ROT_UP;
      if (r < 90) return KIND_ROT_DOWN;
      return KIND_PRINT;
   endfunction

   function automatic logic [3:0] pick_rotate_count();
      if (shadow_depth >= 2 && $urandom_range(0, 3) != 0)
         return 4'($urandom_range(2, (shadow_depth < 9) ? shadow_depth : 9));
      return 4'($urandom_range(0, 9));
   endfunction

   task automatic test_random_stream(input int items, input logic [LIMIT_WIDTH-1:0] limit,
                                     input bit tx_idle, input bit rx_idle);
      logic [2:0] kind;
      write_limit(limit);
      tx_gaps_on   = tx_idle;
      rx_stalls_on = rx_idle;
      repeat (items) begin
         kind = pick_kind();
         send_command(kind, 8'($urandom), pick_rotate_count());
      end
   endtask

   // receiver holds off while the stack is filled to the brim, then a full print
   task automatic test_backpressure();
      write_limit(7'd64);
      tx_gaps_on   = 1'b0;
      rx_stalls_on = 1'b1;
      rx_hold_left = 200;
      while (shadow_depth < STACK_DEPTH) send_command(KIND_PUSH, 8'($urandom), 4'd0);
      send_command(KIND_PUSH, 8'($urandom), 4'd0);
      send_command(KIND_DUP, 8'h00, 4'd0);
      send_command(KIND_ROT_DOWN, 8'h00, 4'd9);
      send_command(KIND_PRINT, 8'h00, 4'd0);
      // sender waits for every result before going on
      drain_results();
      send_command(KIND_PEEK, 8'h00, 4'd0);
      send_command(KIND_ROT_UP, 8'h00, 4'd9);
      send_command(KIND_PRINT, 8'h00, 4'd0);
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_wdata        = STACK_LIMIT_RESET;
      req_valid        = 1'b0;
      req_kind         = KIND_PUSH;
      req_push_byte    = 8'h00;
      req_rotate_count = 4'd0;
      err_count        = 0;
      shadow_depth     = 0;
      shadow_limit     = STACK_LIMIT_RESET;
      rx_hold_left     = 0;
      tx_gaps_on       = 1'b0;
      rx_stalls_on     = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_push_pop_peek();
      test_dup_print();
      test_rotate();
      test_limits();
      test_random_stream(20, 7'd8, 1'b1, 1'b1);
      test_random_stream(10, 7'd1, 1'b1, 1'b0);
      test_random_stream(20, 7'($urandom_range(2, 63)), 1'b0, 1'b1);
      test_random_stream(20, 7'd64, 1'b1, 1'b1);
      test_backpressure();
      drain_results();

      if (err_count == 0) begin
         $display("byte_stack_with_rotate_top_test OK");
      end else begin
         $display("byte_stack_with_rotate_top_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/bsr_pkg.sv
src/bsr_mem.sv
src/bsr_ctrl.sv
src/byte_stack_with_rotate_top.sv
verif/byte_stack_with_rotate_top_test.sv
